// File: design/rn_pkg.sv
package rn_pkg;

   // field widths
   localparam int NUM_W = 32;
   localparam int MAG_W = 31;
   localparam int STS_W = 2;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 72;

   // divider step counter
   localparam int CNT_W = $clog2(MAG_W);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);

   // status codes
   localparam logic [STS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STS_W-1:0] STS_DIV_ZERO = 2'd1;
   localparam logic [STS_W-1:0] STS_OVERFLOW = 2'd2;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_GCD  = 3'd1;
   localparam logic [2:0] ST_DIVN = 3'd2;
   localparam logic [2:0] ST_DIVD = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   localparam logic [NUM_W-1:0] MOST_NEG = 32'h8000_0000;

endpackage

// File: design/rational_normalizer.sv
// channel | direction | handshake            | payload
// req     | in        | req_tvalid/req_tready | tdata: num_in[31:0], den_in[63:32]
// rsp     | out       | rsp_tvalid/rsp_tready | tdata: num_out[31:0], den_out[62:32],
//         |           |                       |        status[64:63], zero[71:65]
//
// one shared restoring divider (one quotient bit per cycle)
// does every Euclid remainder step and then the two final divisions.
// zero numerator and error cases skip the divider and go straight to the final state.
// reset is synchronous and clears the sequencer and the output valid.
// the result sits in an output register, so the next item is taken while
// a result waits; a new result stalls in its final state until the register frees.
module rational_normalizer
   import rn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // num_in[31:0], den_in[63:32]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // num_out, den_out, status, zero pad
);

   logic [2:0]       state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0] out_num_ff, out_num_in;
   logic [MAG_W-1:0] out_den_ff, out_den_in;
   logic [STS_W-1:0] out_sts_ff, out_sts_in;

   logic [MAG_W-1:0] nmag_ff, nmag_in;
   logic [MAG_W-1:0] dmag_ff, dmag_in;
   logic             neg_ff, neg_in;
   logic [MAG_W-1:0] a_ff, a_in;          // divisor, ends up as the gcd
   logic [MAG_W-1:0] qn_ff, qn_in;        // reduced numerator magnitude
   logic [MAG_W-1:0] div_rem_ff, div_rem_in;
   logic [MAG_W-1:0] div_quo_ff, div_quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] res_num_ff, res_num_in;
   logic [MAG_W-1:0] res_den_ff, res_den_in;
   logic [STS_W-1:0] res_sts_ff, res_sts_in;

   logic [NUM_W-1:0] req_num, req_den, req_nabs, req_dabs;
   logic [MAG_W:0]   rem_sh;
   logic [MAG_W+1:0] diff;
   logic             ge, div_last, req_fire;
   logic [MAG_W-1:0] rem_nx, quo_nx;

   assign req_num    = req_tdata[31:0];
   assign req_den    = req_tdata[63:32];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_nabs   = req_num[NUM_W-1] ? (32'd0 - req_num) : req_num;
   assign req_dabs   = req_den[NUM_W-1] ? (32'd0 - req_den) : req_den;

   // shared divider step: shift in the next dividend bit, trial subtract
   assign rem_sh   = {div_rem_ff, div_quo_ff[MAG_W-1]};
   assign diff     = {1'b0, rem_sh} - {2'b00, a_ff};
   assign ge       = !diff[MAG_W+1];
   assign rem_nx   = ge ? diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];
   assign quo_nx   = {div_quo_ff[MAG_W-2:0], ge};
   assign div_last = (cnt_ff == DIV_LAST);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_num_in   = out_num_ff;
      out_den_in   = out_den_ff;
      out_sts_in   = out_sts_ff;
      nmag_in      = nmag_ff;
      dmag_in      = dmag_ff;
      neg_in       = neg_ff;
      a_in         = a_ff;
      qn_in        = qn_ff;
      div_rem_in   = rem_nx;
      div_quo_in   = quo_nx;
      cnt_in       = cnt_ff + 1'b1;
      res_num_in   = res_num_ff;
      res_den_in   = res_den_ff;
      res_sts_in   = res_sts_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in     = '0;
            div_rem_in = '0;
            div_quo_in = req_dabs[MAG_W-1:0];
            if (req_fire) begin
               nmag_in    = req_nabs[MAG_W-1:0];
               dmag_in    = req_dabs[MAG_W-1:0];
               a_in       = req_nabs[MAG_W-1:0];
               neg_in     = req_num[NUM_W-1] ^ req_den[NUM_W-1];
               res_num_in = '0;
               res_den_in = MAG_W'(1);
               res_sts_in = STS_OK;
               state_in   = ST_FIN;
               if (req_num == '0) begin
                  res_sts_in = STS_OK;
               end else if (req_num == MOST_NEG || req_den == MOST_NEG) begin
                  res_sts_in = STS_OVERFLOW;
               end else if (req_den == '0) begin
                  res_sts_in = STS_DIV_ZERO;
               end else begin
                  state_in = ST_GCD;
               end
            end
         end
         // euclid: remainder of dividend by a, until it is zero
         ST_GCD: begin
            if (div_last) begin
               cnt_in     = '0;
               div_rem_in = '0;
               if (rem_nx == '0) begin
                  div_quo_in = nmag_ff;
                  state_in   = ST_DIVN;
               end else begin
                  div_quo_in = a_ff;
                  a_in       = rem_nx;
               end
            end
         end
         // numerator magnitude over gcd
         ST_DIVN: begin
            if (div_last) begin
               cnt_in     = '0;
               div_rem_in = '0;
               div_quo_in = dmag_ff;
               qn_in      = quo_nx;
               state_in   = ST_DIVD;
            end
         end
         // denominator over gcd, then apply the sign
         ST_DIVD: begin
            if (div_last) begin
               res_num_in = neg_ff ? (32'd0 - {1'b0, qn_ff}) : {1'b0, qn_ff};
               res_den_in = quo_nx;
               res_sts_in = STS_OK;
               state_in   = ST_FIN;
            end
         end
         // hand the result to the output register once it is free
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_num_in   = res_num_ff;
               out_den_in   = res_den_ff;
               out_sts_in   = res_sts_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
      out_sts_ff <= out_sts_in;
      nmag_ff    <= nmag_in;
      dmag_ff    <= dmag_in;
      neg_ff     <= neg_in;
      a_ff       <= a_in;
      qn_ff      <= qn_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      cnt_ff     <= cnt_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      res_sts_ff <= res_sts_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, out_sts_ff, out_den_ff, out_num_ff};

   // error results are always 0/1
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_sts_ff != STS_OK |-> out_num_ff == '0 && out_den_ff == MAG_W'(1))
      else $error("error result is not 0/1");

   // denominator is never zero on the output
   a_den_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_den_ff != '0)
      else $error("zero denominator on output");

   // an accepted item makes the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("sequencer idle after accept");

   // divider divisor is never zero while it runs
   a_div_nz: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GCD || state_ff == ST_DIVN || state_ff == ST_DIVD |-> a_ff != '0)
      else $error("divider running with zero divisor");

   // a waiting result is not overwritten
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("pending result lost");

endmodule

// File: bench/testbench.sv
module testbench
   import rn_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 800;
   localparam int QUIET_ITEMS    = 150;
   localparam int HOLD_AT_ITEM   = 200;
   localparam int DRAIN_AT_ITEM  = 420;
   localparam int LONG_HOLD      = 4000;
   localparam int WATCHDOG_LIMIT = 25000;
   localparam int MAX_PRINTED    = 100;

   // one expected reduced fraction, with the item that caused it
   typedef struct {
      logic [NUM_W-1:0] num_in;
      logic [NUM_W-1:0] den_in;
      logic [NUM_W-1:0] num;
      logic [MAG_W-1:0] den;
      logic [STS_W-1:0] sts;
   } fraction_type;

   // expected lowest-terms fractions in arrival order
   class lowest_terms_board;
      fraction_type reduced_q[$];
      int unsigned  errors = 0;

      task report(string msg);
         if (errors < MAX_PRINTED)
            $display("%0t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      function int unsigned pending();
         return reduced_q.size();
      endfunction

      // lowest terms with positive denominator, errors give 0/1
      function fraction_type reduce(logic [NUM_W-1:0] n, logic [NUM_W-1:0] d);
         fraction_type     r;
         logic             n_neg, d_neg;
         logic [NUM_W-1:0] a, b, x, y, rem;
         r.num_in = n;
         r.den_in = d;
         r.num    = '0;
         r.den    = MAG_W'(1);
         r.sts    = STS_OK;
         if (n == '0)
            return r;
         if (n == MOST_NEG || d == MOST_NEG) begin
            r.sts = STS_OVERFLOW;
            return r;
         end
         if (d == '0) begin
            r.sts = STS_DIV_ZERO;
            return r;
         end
         n_neg = n[NUM_W-1];
         d_neg = d[NUM_W-1];
         a = n_neg ? -n : n;
         b = d_neg ? -d : d;
         // euclid on the two nonzero magnitudes
         x   = a;
         y   = b;
         rem = y % x;
         while (rem != '0) begin
            y   = x;
            x   = rem;
            rem = y % x;
         end
         a = a / x;
         b = b / x;
         r.num = (n_neg != d_neg) ? -a : a;
         r.den = b[MAG_W-1:0];
         return r;
      endfunction

      function void note_fraction(logic [NUM_W-1:0] n, logic [NUM_W-1:0] d);
         reduced_q.push_back(reduce(n, d));
      endfunction

      task check_reduced(logic [RSP_DATA_W-1:0] data);
         fraction_type                                want;
         logic [NUM_W-1:0]                            got_num;
         logic [MAG_W-1:0]                            got_den;
         logic [STS_W-1:0]                            got_sts;
         logic [RSP_DATA_W-NUM_W-MAG_W-STS_W-1:0]     got_pad;
         string                                       src;
         got_num = data[NUM_W-1:0];
         got_den = data[NUM_W +: MAG_W];
         got_sts = data[NUM_W+MAG_W +: STS_W];
         got_pad = data[RSP_DATA_W-1:NUM_W+MAG_W+STS_W];
         if (reduced_q.size() == 0) begin
            report($sformatf("item with nothing expected, tdata %h", data));
            return;
         end
         want = reduced_q.pop_front();
         src  = $sformatf("%0d/%0d", $signed(want.num_in), $signed(want.den_in));
         if (got_num !== want.num)
            report($sformatf("%s num_out %0d, want %0d", src, $signed(got_num),
                             $signed(want.num)));
         if (got_den !== want.den)
            report($sformatf("%s den_out %0d, want %0d", src, got_den, want.den));
         if (got_sts !== want.sts)
            report($sformatf("%s status %0d, want %0d", src, got_sts, want.sts));
         if (got_pad !== '0)
            report($sformatf("%s pad bits %h not zero", src, got_pad));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // num_in[31:0], den_in[63:32]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // num_out[31:0], den_out[62:32], status[64:63], pad

   lowest_terms_board board = new;

   bit          tx_gaps   = 1'b1;
   bit          rx_gaps   = 1'b1;
   bit          hold_rsp  = 1'b0;
   int unsigned quiet_cycles = 0;

   rational_normalizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // note accepted items, check accepted results
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_fraction(req_tdata[NUM_W-1:0], req_tdata[REQ_DATA_W-1:NUM_W]);
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_reduced(rsp_tdata);
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stalls, one long hold on request
   initial begin
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // offer one item, wait for it to be taken, then maybe idle a while
   task automatic send_item(input logic [NUM_W-1:0] n, input logic [NUM_W-1:0] d);
      req_tdata  <= {d, n};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (tx_gaps && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // stop offering and wait for every expected fraction
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   function automatic logic [NUM_W-1:0] corner_value();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return MOST_NEG;
         2:       return NUM_W'(1);
         3:       return '1;
         4:       return ~MOST_NEG;
         default: return $urandom;
      endcase
   endfunction

   // mix of full-range pairs, pairs with shared factors, and corners
   task automatic random_pair(output logic [NUM_W-1:0] n, output logic [NUM_W-1:0] d);
      int unsigned pick, g;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         n = $urandom;
         d = $urandom;
      end else if (pick < 90) begin
         if (pick < 78) begin
            g = $urandom_range(1, 1000);
            n = g * $urandom_range(1, 2000);
            d = g * $urandom_range(1, 2000);
         end else begin
            g = $urandom_range(1, 65535);
            n = g * $urandom_range(1, 32767);
            d = g * $urandom_range(1, 32767);
         end
         if ($urandom_range(0, 1)) n = -n;
         if ($urandom_range(0, 1)) d = -d;
      end else begin
         n = corner_value();
         d = corner_value();
      end
   endtask

   // main sequence
   initial begin
      logic [NUM_W-1:0] n, d;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      reset      <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero numerator, with any denominator
      send_item(0, 5);
      send_item(0, 0);
      send_item(0, MOST_NEG);
      // most-negative numerator or denominator
      send_item(MOST_NEG, 3);
      send_item(MOST_NEG, 0);
      send_item(MOST_NEG, MOST_NEG);
      send_item(7, MOST_NEG);
      // zero denominator
      send_item(7, 0);
      send_item(-32'sd7, 0);
      // sign combinations with a shared factor
      send_item(6, 4);
      send_item(-32'sd6, 4);
      send_item(6, -32'sd4);
      send_item(-32'sd6, -32'sd4);
      send_item(12, -32'sd18);
      // unit and extreme magnitudes
      send_item(1, 1);
      send_item('1, '1);
      send_item(1, '1);
      send_item(~MOST_NEG, ~MOST_NEG);
      send_item(-32'sd2147483647, 1);
      send_item(1, -32'sd2147483647);
      send_item(~MOST_NEG, 2);
      // consecutive fibonacci numbers give the longest euclid run
      send_item(32'd1836311903, 32'd1134903170);
      send_item(-32'sd1134903170, 32'd1836311903);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == HOLD_AT_ITEM)
            hold_rsp = 1'b1;
         if (k == DRAIN_AT_ITEM)
            wait_for_drain();
         if (k == RANDOM_ITEMS - QUIET_ITEMS) begin
            tx_gaps = 1'b0;
            rx_gaps = 1'b0;
         end
         random_pair(n, d);
         send_item(n, d);
      end

      // let the last results come out, then a short quiet tail
      wait_for_drain();
      repeat (100) @(posedge clock);
      if (board.errors == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

// File: files.f
design/rn_pkg.sv
design/rational_normalizer.sv
bench/testbench.sv
